FILE: sv/spi_rtc_slave_registers_assert.svh
// ----------------------------------------------------------------------------
// spi_rtc_slave_registers assertion macros
// shared property macros for the port-level checker
// ----------------------------------------------------------------------------
`ifndef SPI_RTC_SLAVE_REGISTERS_ASSERT_SVH
`define SPI_RTC_SLAVE_REGISTERS_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SRTC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srtc assertion failed");

// next-cycle implication, disabled in reset
`define SRTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srtc assertion failed");

`endif

FILE: sv/srtc_pkg.sv
// ----------------------------------------------------------------------------
// srtc_pkg
// shared codes, constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package srtc_pkg;

  // input action codes
  localparam logic [1:0] ACT_SELECT = 2'd0;
  localparam logic [1:0] ACT_BYTE   = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  // register map seen over spi
  localparam logic [7:0] REG_SECONDS = 8'd2;
  localparam logic [7:0] REG_MINUTES = 8'd3;
  localparam logic [7:0] REG_HOURS   = 8'd4;
  localparam logic [7:0] REG_OFFSET  = 8'h0D;

  // configuration register indexes
  localparam logic [1:0] CFG_FACTORY = 2'd0;
  localparam logic [1:0] CFG_TEMP_EN = 2'd1;

  // floor(n / 100) = (n * RECIP_100) >> RECIP_SHIFT for n < 43690
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic latch;     // capture the accepted item
    logic exec;      // apply the item to the register set
    logic mul;       // reciprocal multiply for the divide by 100
    logic quo;       // take quotient into the selected offset
    logic calib;     // clamp offset sum into the calibration word
    logic load_out;  // load the result register
  } cmd_t;

  typedef struct packed {
    logic need_calib;  // current item recomputes the calibration word
  } status_t;

endpackage

FILE: sv/srtc_ctrl.sv
// ----------------------------------------------------------------------------
// srtc_ctrl
// sequencing state machine for item execution and result handoff
// ----------------------------------------------------------------------------
module srtc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  srtc_pkg::status_t status,
  output srtc_pkg::cmd_t    cmd
);
  import srtc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_QUO,
    S_CALIB,
    S_OUT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.latch    = (state == S_IDLE) && in_valid;
    cmd.exec     = (state == S_EXEC);
    cmd.mul      = (state == S_MUL);
    cmd.quo      = (state == S_QUO);
    cmd.calib    = (state == S_CALIB);
    cmd.load_out = (state == S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= status.need_calib ? S_MUL : S_OUT;
        end
        S_MUL:   state <= S_QUO;
        S_QUO:   state <= S_CALIB;
        S_CALIB: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/srtc_datapath.sv
// ----------------------------------------------------------------------------
// srtc_datapath
// register set, clock counters, offset arithmetic and result register
// ----------------------------------------------------------------------------
module srtc_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic [1:0]        action,
  input  logic [7:0]        spi_byte,
  input  logic signed [7:0] temperature_c,
  input  srtc_pkg::cmd_t     cmd,
  output srtc_pkg::status_t  status,
  output logic [7:0]        reply_byte,
  output logic [7:0]        calib_word,
  output logic              calib_updated,
  output logic [7:0]        hours_now,
  output logic [7:0]        minutes_now,
  output logic [7:0]        seconds_now
);
  import srtc_pkg::*;

  // configuration
  logic signed [7:0] factory_ppm;
  logic              temp_comp_enable;

  // architectural state
  logic [7:0]        reg_pointer;
  logic              write_mode;
  logic [7:0]        second_count;
  logic [7:0]        minute_count;
  logic [7:0]        hour_count;
  logic signed [9:0] user_offset;
  logic signed [9:0] temp_offset;
  logic [7:0]        calib_reg;

  // captured item and working registers
  logic [1:0]        item_action;
  logic [7:0]        item_byte;
  logic signed [7:0] item_temp;
  logic [14:0]       div_num;
  logic              div_neg;
  logic              div_to_temp;
  logic [27:0]       div_prod;
  logic [7:0]        reply_val;
  logic              updated_val;

  // byte decode
  logic       is_command;
  logic       eff_write;
  logic       advance;
  logic [7:0] eff_pointer;
  logic [7:0] bcd_val;
  logic [7:0] read_reply;
  logic       offset_write;

  // offset write
  logic [6:0]  off_mag;
  logic [14:0] user_num;

  // tick
  logic [7:0] sec_inc;
  logic [7:0] min_inc;
  logic [7:0] hour_inc;
  logic       roll_sec;
  logic       roll_min;
  logic       roll_hour;
  logic       comp_roll;

  // temperature term
  logic signed [7:0] temp_sat;
  logic signed [8:0] temp_delta;
  logic [6:0]        diff_mag;
  logic [13:0]       diff_sq;
  logic [14:0]       temp_num;

  // quotient and calibration
  logic [8:0]         quotient;
  logic signed [9:0]  quotient_signed;
  logic signed [10:0] offset_sum;
  logic [6:0]         calib_mag;

  function automatic logic [7:0] bcd_encode(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  tens;
    logic [7:0]  ones;
    prod = {8'd0, v} * 16'd205;
    tens = prod[15:11];
    ones = v - 8'({3'd0, tens} * 8'd10);
    return 8'({tens, 4'b0000}) | {4'b0000, ones[3:0]};
  endfunction

  always_comb begin
    is_command   = (reg_pointer == 8'd0);
    eff_write    = is_command ? !item_byte[7] : write_mode;
    eff_pointer  = is_command ? {4'd0, item_byte[3:0]} : reg_pointer;
    advance      = !(is_command && !item_byte[7]);
    offset_write = (item_action == ACT_BYTE) && advance && eff_write &&
                   (eff_pointer == REG_OFFSET);

    case (eff_pointer)
      REG_SECONDS: bcd_val = second_count;
      REG_MINUTES: bcd_val = minute_count;
      REG_HOURS:   bcd_val = hour_count;
      default:     bcd_val = 8'd0;
    endcase
    read_reply = (advance && !eff_write) ? bcd_encode(bcd_val) : 8'd0;

    // 7-bit signed offset, magnitude times 434
    off_mag  = item_byte[6] ? 7'(-item_byte[6:0]) : item_byte[6:0];
    user_num = 15'({8'd0, off_mag} * 15'd434);

    sec_inc   = second_count + 8'd1;
    min_inc   = minute_count + 8'd1;
    hour_inc  = hour_count + 8'd1;
    roll_sec  = (sec_inc >= 8'd60);
    roll_min  = (min_inc >= 8'd60);
    roll_hour = (hour_inc >= 8'd24);
    comp_roll = (item_action == ACT_TICK) && roll_sec && temp_comp_enable;

    // saturate to -40..125, then 3 * (t - 25)^2 + 50 for the rounded divide
    if (item_temp < -8'sd40) begin
      temp_sat = -8'sd40;
    end else if (item_temp > 8'sd125) begin
      temp_sat = 8'sd125;
    end else begin
      temp_sat = item_temp;
    end
    temp_delta = 9'(temp_sat) - 9'sd25;
    diff_mag   = temp_delta[8] ? 7'(-temp_delta) : temp_delta[6:0];
    diff_sq    = {7'd0, diff_mag} * {7'd0, diff_mag};
    temp_num   = 15'({1'b0, diff_sq} * 15'd3) + 15'd50;

    status.need_calib = offset_write || comp_roll;

    quotient        = div_prod[27:RECIP_SHIFT];
    quotient_signed = div_neg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});

    offset_sum = 11'(user_offset) + 11'(factory_ppm) + 11'(temp_offset);
    if (offset_sum < -11'sd127) begin
      calib_mag = 7'd127;
    end else if (offset_sum > 11'sd127) begin
      calib_mag = 7'd127;
    end else if (offset_sum[10]) begin
      calib_mag = 7'(-offset_sum);
    end else begin
      calib_mag = offset_sum[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      factory_ppm      <= '0;
      temp_comp_enable <= 1'b0;
      reg_pointer      <= '0;
      write_mode       <= 1'b0;
      second_count     <= '0;
      minute_count     <= '0;
      hour_count       <= '0;
      user_offset      <= '0;
      temp_offset      <= '0;
      calib_reg        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FACTORY: factory_ppm      <= $signed(cfg_data);
          CFG_TEMP_EN: temp_comp_enable <= cfg_data[0];
          default: ;
        endcase
      end

      if (cmd.exec) begin
        case (item_action)
          ACT_SELECT: begin
            reg_pointer <= '0;
            write_mode  <= 1'b0;
          end
          ACT_BYTE: begin
            if (is_command) write_mode <= !item_byte[7];
            if (advance) begin
              reg_pointer <= eff_pointer + 8'd1;
              if (eff_write) begin
                case (eff_pointer)
                  REG_SECONDS: second_count <= 8'({4'd0, item_byte[7:4]} * 8'd10) +
                                               {4'd0, item_byte[3:0]};
                  REG_MINUTES: minute_count <= 8'({4'd0, item_byte[7:4]} * 8'd10) +
                                               {4'd0, item_byte[3:0]};
                  REG_HOURS:   hour_count   <= 8'({4'd0, item_byte[7:4]} * 8'd10) +
                                               {4'd0, item_byte[3:0]};
                  default: ;
                endcase
              end
            end else begin
              reg_pointer <= eff_pointer;
            end
          end
          ACT_TICK: begin
            if (roll_sec) begin
              second_count <= '0;
              if (roll_min) begin
                minute_count <= '0;
                hour_count   <= roll_hour ? 8'd0 : hour_inc;
              end else begin
                minute_count <= min_inc;
              end
            end else begin
              second_count <= sec_inc;
            end
          end
          default: ;
        endcase
      end

      if (cmd.quo) begin
        if (div_to_temp) begin
          temp_offset <= quotient_signed;
        end else begin
          user_offset <= quotient_signed;
        end
      end

      if (cmd.calib) begin
        calib_reg <= {offset_sum[10], calib_mag};
      end
    end
  end

  // working and payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_action <= action;
      item_byte   <= spi_byte;
      item_temp   <= temperature_c;
    end
    if (cmd.exec) begin
      reply_val   <= (item_action == ACT_BYTE) ? read_reply : 8'd0;
      updated_val <= 1'b0;
      div_to_temp <= comp_roll;
      div_neg     <= comp_roll ? 1'b1 : item_byte[6];
      div_num     <= comp_roll ? temp_num : user_num;
    end
    if (cmd.mul) begin
      div_prod <= {13'd0, div_num} * {15'd0, RECIP_100};
    end
    if (cmd.calib) begin
      updated_val <= 1'b1;
    end
    if (cmd.load_out) begin
      reply_byte    <= reply_val;
      calib_word    <= calib_reg;
      calib_updated <= updated_val;
      hours_now     <= hour_count;
      minutes_now   <= minute_count;
      seconds_now   <= second_count;
    end
  end

endmodule

FILE: sv/spi_rtc_slave_registers.sv
// ----------------------------------------------------------------------------
// spi_rtc_slave_registers
// spi-slave real-time clock register set with sign-magnitude calibration
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one transaction per spi event:
//   a select start, a received spi byte, or a one-second tick with the chip
//   temperature. output channel (out_valid / out_stall) returns exactly one
//   result per input transaction: the reply byte for the next spi transfer,
//   the calibration word, its update flag and the current hh:mm:ss in binary.
//   sequence: an item is executed and its result then loaded; when it
//   recomputes the calibration word (offset write or compensated minute
//   rollover), the reciprocal multiply for the divide by 100, the quotient
//   step and the clamp of the offset sum come in between. the next item
//   is accepted the cycle after its predecessor's result is loaded.
//   stall: a result waits in the output register while out_stall is high;
//   the block already takes the next transaction, and holds that one's result
//   internally until the output register frees up.
//   reset: rst (synchronous, active high) clears clock, pointer, offsets,
//   calibration word and the configuration registers to zero.
//   configuration: cfg_we / cfg_index / cfg_data, index 0 factory offset in
//   ppm (signed), index 1 temperature compensation enable; write only while idle
// ----------------------------------------------------------------------------
module spi_rtc_slave_registers (
  input  logic              clk,
  input  logic              rst,
  // configuration write port
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  // input transactions
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  logic [7:0]        spi_byte,
  input  logic signed [7:0] temperature_c,
  // result transactions
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        reply_byte,
  output logic [7:0]        calib_word,
  output logic              calib_updated,
  output logic [7:0]        hours_now,
  output logic [7:0]        minutes_now,
  output logic [7:0]        seconds_now
);
  import srtc_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: accept, execute, optional calibration steps, result handoff
  srtc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // register set, counters, offset arithmetic and output register
  srtc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .spi_byte      (spi_byte),
    .temperature_c (temperature_c),
    .cmd           (cmd),
    .status        (status),
    .reply_byte    (reply_byte),
    .calib_word    (calib_word),
    .calib_updated (calib_updated),
    .hours_now     (hours_now),
    .minutes_now   (minutes_now),
    .seconds_now   (seconds_now)
  );

endmodule

FILE: sv/srtc_checker.sv
// ----------------------------------------------------------------------------
// srtc_checker
// port-level assertions, bound to the top level
// ----------------------------------------------------------------------------
`include "spi_rtc_slave_registers_assert.svh"

module srtc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] reply_byte,
  input logic [7:0] calib_word
);

  // a stalled result stays
  `SRTC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // a stalled result keeps its payload
  `SRTC_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall,
                    $stable(reply_byte) && $stable(calib_word))

  // one transaction at a time: busy right after an accept
  `SRTC_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // a new result comes out together with readiness for the next transaction
  `SRTC_ASSERT_NOW(a_ready_with_result, clk, rst, $rose(out_valid), !in_stall)

endmodule

bind spi_rtc_slave_registers srtc_checker u_srtc_checker (.*);

FILE: verif/tb_spi_rtc_slave_registers.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spi_rtc_slave_registers
// self-checking bench for the spi rtc register set: a queue-fed driver sends
// select starts, spi bytes and ticks in bursts, a monitor stalls on its own
// pattern and checks every result against an in-bench model of the clock,
// the register pointer and the calibration word
// ----------------------------------------------------------------------------
module tb_spi_rtc_slave_registers;
  import srtc_pkg::*;

  // action code the block must ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // user offset step is 4.34 ppm, kept as hundredths
  localparam int OFFSET_STEP_X100 = 434;
  localparam int CALIB_MAX        = 127;

  // generous bound, far above the slowest legal run
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]        action;
    logic [7:0]        spi_byte;
    logic signed [7:0] temperature_c;
  } rtc_item_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic [7:0] calib_word;
    logic       calib_updated;
    logic [7:0] hours_now;
    logic [7:0] minutes_now;
    logic [7:0] seconds_now;
  } rtc_result_t;

  // clock, reset and dut ports; the driven inputs are known from time zero
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = CFG_FACTORY;
  logic [7:0]        cfg_data = 8'h00;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        action = ACT_SELECT;
  logic [7:0]        spi_byte = 8'h00;
  logic signed [7:0] temperature_c = 8'sd0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        reply_byte;
  logic [7:0]        calib_word;
  logic              calib_updated;
  logic [7:0]        hours_now;
  logic [7:0]        minutes_now;
  logic [7:0]        seconds_now;

  // stimulus waiting to be sent and results waiting to arrive
  rtc_item_t   pending_q[$];
  rtc_result_t expect_q[$];
  int          n_queued = 0;

  // transaction counters, updated with nonblocking writes so that both
  // always blocks see the same pre-edge values
  int n_accepted = 0;
  int n_checked  = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // model of the register set
  logic [7:0] m_ptr;
  logic       m_write;
  logic [7:0] m_sec;
  logic [7:0] m_min;
  logic [7:0] m_hr;
  int         m_user;
  int         m_temp;
  logic [7:0] m_calib;
  int         m_factory;
  logic       m_comp_en;

  // driver state
  rtc_item_t cur_item;
  int        burst_left = 0;
  int        gap_left = 0;
  bit        drain_hold = 1'b0;

  // monitor state
  rtc_result_t got;
  rtc_result_t want;
  int          stall_mode = 0;
  int          stall_run = 0;
  int          stall_phase = 0;

  spi_rtc_slave_registers u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .spi_byte      (spi_byte),
    .temperature_c (temperature_c),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .reply_byte    (reply_byte),
    .calib_word    (calib_word),
    .calib_updated (calib_updated),
    .hours_now     (hours_now),
    .minutes_now   (minutes_now),
    .seconds_now   (seconds_now)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // model of the block
  // ------------------------------------------------------------------

  // bcd digits to binary, invalid digits included (up to 165)
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    return 8'(b[7:4] * 10 + b[3:0]);
  endfunction

  // binary to bcd, tens digit kept to four bits
  function automatic logic [7:0] bin_to_bcd(input logic [7:0] v);
    logic [7:0] tens;
    logic [7:0] units;
    tens  = v / 8'd10;
    units = v % 8'd10;
    return {tens[3:0], units[3:0]};
  endfunction

  // clamp the offset sum and code it as sign and magnitude
  function automatic void refresh_calib();
    int total;
    total = m_user + m_factory + m_temp;
    if (total < -CALIB_MAX) total = -CALIB_MAX;
    else if (total > CALIB_MAX) total = CALIB_MAX;
    if (total < 0) m_calib = {1'b1, 7'(-total)};
    else m_calib = {1'b0, 7'(total)};
  endfunction

  function automatic rtc_result_t predict_rtc(input rtc_item_t it);
    rtc_result_t r;
    bit          advance;
    int          off;
    int          t;
    int          diff;
    int          x;
    r = '0;
    case (it.action)
      ACT_SELECT: begin
        m_ptr   = 8'h00;
        m_write = 1'b0;
      end
      ACT_BYTE: begin
        advance = 1'b1;
        // pointer at zero: this byte is a command
        if (m_ptr == 8'h00) begin
          m_write = !it.spi_byte[7];
          m_ptr   = {4'h0, it.spi_byte[3:0]};
          if (m_write) advance = 1'b0;
        end
        if (advance) begin
          if (m_write) begin
            case (m_ptr)
              REG_SECONDS: m_sec = bcd_to_bin(it.spi_byte);
              REG_MINUTES: m_min = bcd_to_bin(it.spi_byte);
              REG_HOURS:   m_hr  = bcd_to_bin(it.spi_byte);
              REG_OFFSET: begin
                // 7-bit signed offset, scaled and truncated toward zero
                off = int'(it.spi_byte[6:0]);
                if (it.spi_byte[6]) off = off - 128;
                m_user = (off * OFFSET_STEP_X100) / 100;
                refresh_calib();
                r.calib_updated = 1'b1;
              end
              default: ;
            endcase
          end else begin
            case (m_ptr)
              REG_SECONDS: r.reply_byte = bin_to_bcd(m_sec);
              REG_MINUTES: r.reply_byte = bin_to_bcd(m_min);
              REG_HOURS:   r.reply_byte = bin_to_bcd(m_hr);
              default: ;
            endcase
          end
          m_ptr = m_ptr + 8'd1;
        end
      end
      ACT_TICK: begin
        m_sec = m_sec + 8'd1;
        if (m_sec >= 8'd60) begin
          m_sec = 8'd0;
          m_min = m_min + 8'd1;
          if (m_min >= 8'd60) begin
            m_min = 8'd0;
            m_hr  = m_hr + 8'd1;
            if (m_hr >= 8'd24) m_hr = 8'd0;
          end
          if (m_comp_en) begin
            // saturate to the rated range, then -0.03 ppm per square degree
            t = int'(it.temperature_c);
            if (t < -40) t = -40;
            else if (t > 125) t = 125;
            diff = t - 25;
            x = -3 * diff * diff;
            m_temp = (x >= 0) ? (x + 50) / 100 : (x - 50) / 100;
            refresh_calib();
            r.calib_updated = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.calib_word  = m_calib;
    r.hours_now   = m_hr;
    r.minutes_now = m_min;
    r.seconds_now = m_sec;
    return r;
  endfunction

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------

  task automatic queue_item(input logic [1:0] act, input logic [7:0] b,
                            input logic [7:0] t);
    rtc_item_t it;
    it.action        = act;
    it.spi_byte      = b;
    it.temperature_c = t;
    pending_q.push_back(it);
    n_queued++;
  endtask

  // mostly rated temperatures, sometimes any byte
  function automatic logic [7:0] rand_temp();
    int t;
    if ($urandom_range(0, 6) == 0) return 8'($urandom);
    t = $urandom_range(0, 165) - 40;
    return 8'(t);
  endfunction

  // data bytes lean toward x5..x9 in the fifties so ticks reach rollovers
  function automatic logic [7:0] data_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return {4'd5, 4'($urandom_range(5, 9))};
    if (pick < 75) return {4'($urandom_range(0, 5)), 4'($urandom_range(0, 9))};
    return 8'($urandom);
  endfunction

  // one random phase: mostly whole spi frames, runs of ticks, some noise
  task automatic queue_random_phase(input int n_items, input bit with_wrap);
    int         target;
    int         pick;
    int         n_data;
    logic [7:0] cmd;
    logic [3:0] start;
    target = n_queued + n_items;
    if (with_wrap) begin
      // long read burst: the pointer wraps past 255 and the next byte
      // is taken as a command
      queue_item(ACT_SELECT, 8'($urandom), rand_temp());
      cmd = 8'($urandom);
      cmd[7] = 1'b1;
      queue_item(ACT_BYTE, cmd, rand_temp());
      repeat (262) queue_item(ACT_BYTE, 8'($urandom), rand_temp());
    end
    while (n_queued < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        case ($urandom_range(0, 4))
          0: start = REG_SECONDS[3:0];
          1: start = REG_MINUTES[3:0];
          2: start = REG_HOURS[3:0];
          3: start = REG_OFFSET[3:0];
          default: start = 4'($urandom);
        endcase
        cmd = 8'($urandom);
        cmd[3:0] = start;
        queue_item(ACT_SELECT, 8'($urandom), rand_temp());
        queue_item(ACT_BYTE, cmd, rand_temp());
        n_data = $urandom_range(1, 5);
        repeat (n_data) queue_item(ACT_BYTE, data_byte(), rand_temp());
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 8)) queue_item(ACT_TICK, 8'($urandom), rand_temp());
      end else begin
        queue_item(2'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // both registers back to back, only while the block is idle
  task automatic program_config(input int factory, input logic comp_en);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FACTORY;
    cfg_data  <= 8'(factory);
    m_factory = factory;
    @(posedge clk);
    cfg_index <= CFG_TEMP_EN;
    cfg_data  <= {7'd0, comp_en};
    m_comp_en = comp_en;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // settled view at the falling edge: nothing queued, sent or in flight
  task automatic wait_idle();
    @(negedge clk);
    while (pending_q.size() != 0 || in_valid || n_accepted != n_checked)
      @(negedge clk);
  endtask

  // ------------------------------------------------------------------
  // driver: bursts of transactions with random gaps between them
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
      drain_hold = 1'b0;
      // model state and configuration after reset
      m_ptr     = 8'h00;
      m_write   = 1'b0;
      m_sec     = 8'd0;
      m_min     = 8'd0;
      m_hr      = 8'd0;
      m_user    = 0;
      m_temp    = 0;
      m_calib   = 8'h00;
      m_factory = 0;
      m_comp_en = 1'b0;
    end else begin
      // accepted transaction: predict its result now
      if (in_valid && !in_stall) begin
        expect_q.push_back(predict_rtc(cur_item));
        n_accepted <= n_accepted + 1;
      end
      // payload holds while stalled
      if (!in_valid || !in_stall) begin
        // pause lifts once every result so far has come back
        if (drain_hold && n_accepted == n_checked && !in_valid) drain_hold = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (drain_hold || pending_q.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          cur_item = pending_q.pop_front();
          action        <= cur_item.action;
          spi_byte      <= cur_item.spi_byte;
          temperature_c <= cur_item.temperature_c;
          in_valid      <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = $urandom_range(1, 8);
            // now and then wait for the pipeline to empty completely
            if ($urandom_range(0, 15) == 0) drain_hold = 1'b1;
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // monitor: own stall pattern, compares each result with the oldest
  // expectation
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_checked <= n_checked + 1;
        got = '{reply_byte, calib_word, calib_updated, hours_now, minutes_now,
                seconds_now};
        if (expect_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: reply=%02h calib=%02h upd=%0d %0d:%0d:%0d",
                     got.reply_byte, got.calib_word, got.calib_updated,
                     got.hours_now, got.minutes_now, got.seconds_now);
        end else begin
          want = expect_q.pop_front();
          if (got.reply_byte !== want.reply_byte || got.calib_word !== want.calib_word ||
              got.calib_updated !== want.calib_updated ||
              got.hours_now !== want.hours_now || got.minutes_now !== want.minutes_now ||
              got.seconds_now !== want.seconds_now) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("result %0d mismatch, expected: reply=%02h calib=%02h upd=%0d %0d:%0d:%0d",
                       n_checked, want.reply_byte, want.calib_word, want.calib_updated,
                       want.hours_now, want.minutes_now, want.seconds_now);
              $display("result %0d mismatch, actual:   reply=%02h calib=%02h upd=%0d %0d:%0d:%0d",
                       n_checked, got.reply_byte, got.calib_word, got.calib_updated,
                       got.hours_now, got.minutes_now, got.seconds_now);
            end
          end
        end
      end
      // stall modes in stretches: none, sparse random, periodic, heavy
      if (stall_run <= 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_run  = $urandom_range(10, 60);
      end
      stall_run--;
      stall_phase++;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= (stall_phase % 4 != 0);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // test sequence
  // ------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part: lowest factory offset with compensation on
    program_config(-128, 1'b1);
    queue_item(ACT_SELECT, 8'h00, 8'sd0);
    // write command at the seconds register: the command byte itself writes nothing
    queue_item(ACT_BYTE, 8'h02, 8'sd0);
    queue_item(ACT_BYTE, 8'h59, 8'sd0);
    queue_item(ACT_BYTE, 8'h59, 8'sd0);
    queue_item(ACT_BYTE, 8'h23, 8'sd0);
    // register with no function, write ignored
    queue_item(ACT_BYTE, 8'hFF, 8'sd0);
    // full rollover to midnight, temperature below range gets saturated
    queue_item(ACT_TICK, 8'h00, 8'h80);
    // largest and smallest user offsets, the sum clamps with the smallest
    queue_item(ACT_SELECT, 8'hFF, 8'sd0);
    queue_item(ACT_BYTE, 8'h0D, 8'sd0);
    queue_item(ACT_BYTE, 8'h3F, 8'sd0);
    queue_item(ACT_SELECT, 8'h00, 8'sd0);
    queue_item(ACT_BYTE, 8'h0D, 8'sd0);
    queue_item(ACT_BYTE, 8'h40, 8'sd0);
    // write command at register zero: next byte is a command again
    queue_item(ACT_SELECT, 8'h00, 8'sd0);
    queue_item(ACT_BYTE, 8'h00, 8'sd0);
    // read burst from seconds through a register with no function
    queue_item(ACT_BYTE, 8'h82, 8'sd0);
    queue_item(ACT_BYTE, 8'h00, 8'sd0);
    queue_item(ACT_BYTE, 8'hFF, 8'sd0);
    queue_item(ACT_BYTE, 8'h00, 8'sd0);
    // invalid bcd seconds, the next tick rolls over from out of range,
    // temperature above range gets saturated
    queue_item(ACT_SELECT, 8'h00, 8'sd0);
    queue_item(ACT_BYTE, 8'h02, 8'sd0);
    queue_item(ACT_BYTE, 8'hFF, 8'sd0);
    queue_item(ACT_TICK, 8'hFF, 8'h7F);
    // unused action leaves everything alone
    queue_item(ACT_UNUSED, 8'hFF, 8'hFF);
    queue_item(ACT_TICK, 8'h00, 8'sd25);
    wait_idle();
    repeat (8) @(posedge clk);

    // random phases; a factory write alone leaves the calibration word as is
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: program_config(0, 1'b0);
        1: program_config(127, 1'b1);
        2: program_config(-128, 1'b0);
        3: program_config($urandom_range(0, 255) - 128, 1'b1);
        default: program_config($urandom_range(0, 255) - 128, 1'($urandom));
      endcase
      queue_random_phase(255, phase == 1);
      wait_idle();
      repeat (8) @(posedge clk);
    end

    // trailing cycles catch any stray result
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
